>>> rtl/core/gcw_pkg.sv
// Package for glyph_cell_width: payload structs, spelling constants, range tables.
// No dependencies.
package gcw_pkg;

    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  source_bytes;
    } gcw_in_t;

    typedef struct packed {
        logic [2:0] cell_width;
        logic       is_escaped;
        logic [2:0] spelling_length;
        logic [6:0] spell_char0;
        logic [6:0] spell_char1;
        logic [6:0] spell_char2;
        logic [6:0] spell_char3;
    } gcw_out_t;

    // classification carried from the first stage
    typedef enum logic [1:0] {
        CLS_CARET = 2'd0,
        CLS_HEX   = 2'd1,
        CLS_ONE   = 2'd2,
        CLS_TABLE = 2'd3
    } gcw_cls_t;

    localparam logic [20:0] SHORT_CUT_LIMIT = 21'h000300;
    localparam logic [6:0]  CH_CARET = 7'h5E;
    localparam logic [6:0]  CH_BSLASH = 7'h5C;
    localparam logic [6:0]  CH_X = 7'h78;
    localparam logic [6:0]  CH_QUEST = 7'h3F;
    localparam logic [6:0]  CH_AT = 7'h40;

    localparam int ZW_N = 46;
    localparam int DW_N = 120;

    localparam logic [20:0] ZW_LO [ZW_N] = '{
        21'h0300,21'h0483,21'h0591,21'h05BF,21'h05C1,21'h05C4,21'h05C7,21'h0610,
        21'h064B,21'h0670,21'h06D6,21'h06DF,21'h06E7,21'h06EA,21'h0711,21'h0730,
        21'h07A6,21'h07EB,21'h0816,21'h081B,21'h0825,21'h0829,21'h0859,21'h0E31,
        21'h0E34,21'h0E47,21'h0EB1,21'h0EB4,21'h0EC8,21'h1160,21'h180B,21'h1AB0,
        21'h1DC0,21'h200B,21'h202A,21'h2060,21'h206A,21'h20D0,21'h3099,21'hD7B0,
        21'hD7CB,21'hFE00,21'hFE20,21'hFEFF,21'hE0000,21'hE0100};
    localparam logic [20:0] ZW_HI [ZW_N] = '{
        21'h036F,21'h0489,21'h05BD,21'h05BF,21'h05C2,21'h05C5,21'h05C7,21'h061A,
        21'h065F,21'h0670,21'h06DC,21'h06E4,21'h06E8,21'h06ED,21'h0711,21'h074A,
        21'h07B0,21'h07F3,21'h0819,21'h0823,21'h0827,21'h082D,21'h085B,21'h0E31,
        21'h0E3A,21'h0E4E,21'h0EB1,21'h0EBC,21'h0ECD,21'h11FF,21'h180E,21'h1AFF,
        21'h1DFF,21'h200F,21'h202E,21'h2064,21'h206F,21'h20F0,21'h309A,21'hD7C6,
        21'hD7FB,21'hFE0F,21'hFE2F,21'hFEFF,21'hE007F,21'hE01EF};

    localparam logic [20:0] DW_LO [DW_N] = '{
        21'h1100,21'h231A,21'h2329,21'h23E9,21'h23F0,21'h23F3,21'h25FD,21'h2614,
        21'h2648,21'h267F,21'h2693,21'h26A1,21'h26AA,21'h26BD,21'h26C4,21'h26CE,
        21'h26D4,21'h26EA,21'h26F2,21'h26F5,21'h26FA,21'h26FD,21'h2705,21'h270A,
        21'h2728,21'h274C,21'h274E,21'h2753,21'h2757,21'h2795,21'h27B0,21'h27BF,
        21'h2B1B,21'h2B50,21'h2B55,21'h2E80,21'h2E9B,21'h2F00,21'h2FF0,21'h3041,
        21'h3099,21'h3105,21'h3131,21'h3190,21'h31EF,21'h3220,21'h3250,21'h4E00,
        21'hA490,21'hA960,21'hAC00,21'hF900,21'hFE10,21'hFE30,21'hFE54,21'hFE68,
        21'hFF01,21'hFFE0,21'h16FE0,21'h16FF0,21'h17000,21'h18800,21'h18D00,21'h1AFF0,
        21'h1AFF5,21'h1AFFD,21'h1B000,21'h1B132,21'h1B150,21'h1B155,21'h1B164,21'h1B170,
        21'h1F004,21'h1F0CF,21'h1F18E,21'h1F191,21'h1F200,21'h1F210,21'h1F240,21'h1F250,
        21'h1F260,21'h1F300,21'h1F32D,21'h1F337,21'h1F37E,21'h1F3A0,21'h1F3CF,21'h1F3E0,
        21'h1F3F4,21'h1F3F8,21'h1F440,21'h1F442,21'h1F4FF,21'h1F54B,21'h1F550,21'h1F57A,
        21'h1F595,21'h1F5A4,21'h1F5FB,21'h1F680,21'h1F6CC,21'h1F6D0,21'h1F6D5,21'h1F6DC,
        21'h1F6EB,21'h1F6F4,21'h1F7E0,21'h1F7F0,21'h1F90C,21'h1F93C,21'h1F947,21'h1FA70,
        21'h1FA80,21'h1FA90,21'h1FABF,21'h1FACE,21'h1FAE0,21'h1FAF0,21'h20000,21'h30000};
    localparam logic [20:0] DW_HI [DW_N] = '{
        21'h115F,21'h231B,21'h232A,21'h23EC,21'h23F0,21'h23F3,21'h25FE,21'h2615,
        21'h2653,21'h267F,21'h2693,21'h26A1,21'h26AB,21'h26BE,21'h26C5,21'h26CE,
        21'h26D4,21'h26EA,21'h26F3,21'h26F5,21'h26FA,21'h26FD,21'h2705,21'h270B,
        21'h2728,21'h274C,21'h274E,21'h2755,21'h2757,21'h2797,21'h27B0,21'h27BF,
        21'h2B1C,21'h2B50,21'h2B55,21'h2E99,21'h2EF3,21'h2FD5,21'h303E,21'h3096,
        21'h30FF,21'h312F,21'h318E,21'h31E3,21'h321E,21'h3247,21'h4DBF,21'hA48C,
        21'hA4C6,21'hA97C,21'hD7A3,21'hFAFF,21'hFE19,21'hFE52,21'hFE66,21'hFE6B,
        21'hFF60,21'hFFE6,21'h16FE4,21'h16FF1,21'h187F7,21'h18CD5,21'h18D08,21'h1AFF3,
        21'h1AFFB,21'h1AFFE,21'h1B122,21'h1B132,21'h1B152,21'h1B155,21'h1B167,21'h1B2FB,
        21'h1F004,21'h1F0CF,21'h1F18E,21'h1F19A,21'h1F202,21'h1F23B,21'h1F248,21'h1F251,
        21'h1F265,21'h1F320,21'h1F335,21'h1F37C,21'h1F393,21'h1F3CA,21'h1F3D3,21'h1F3F0,
        21'h1F3F4,21'h1F43E,21'h1F440,21'h1F4FC,21'h1F53D,21'h1F54E,21'h1F567,21'h1F57A,
        21'h1F596,21'h1F5A4,21'h1F64F,21'h1F6C5,21'h1F6CC,21'h1F6D2,21'h1F6D7,21'h1F6DF,
        21'h1F6EC,21'h1F6FC,21'h1F7EB,21'h1F7F0,21'h1F93A,21'h1F945,21'h1F9FF,21'h1FA7C,
        21'h1FA88,21'h1FABD,21'h1FAC5,21'h1FADB,21'h1FAE8,21'h1FAF8,21'h2FFFD,21'h3FFFD};

    // lowercase hex digit for a nibble
    function automatic logic [6:0] hex_char(input logic [3:0] n);
        hex_char = (n < 4'd10) ? (7'h30 + {3'd0, n}) : (7'h57 + {3'd0, n});
    endfunction

endpackage

>>> rtl/core/gcw_range_hit.sv
// Registered range lookup: per-range compares in one stage, OR tree in the next.
// Depends on gcw_pkg.
module gcw_range_hit
    import gcw_pkg::*;
(
    input  logic        clk,
    input  logic        adv,
    input  logic [20:0] code_point,
    output logic        zw_hit,
    output logic        dw_hit
);

    logic [ZW_N-1:0] zw_vec_reg;
    logic [DW_N-1:0] dw_vec_reg;
    logic [ZW_N-1:0] zw_vec_next;
    logic [DW_N-1:0] dw_vec_next;

    // compare against every range in parallel
    always_comb
    begin
        for (int i = 0; i < ZW_N; i++)
        begin
            zw_vec_next[i] = (code_point >= ZW_LO[i]) && (code_point <= ZW_HI[i]);
        end
        for (int j = 0; j < DW_N; j++)
        begin
            dw_vec_next[j] = (code_point >= DW_LO[j]) && (code_point <= DW_HI[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zw_vec_reg <= zw_vec_next;
            dw_vec_reg <= dw_vec_next;
        end
    end

    assign zw_hit = |zw_vec_reg;
    assign dw_hit = |dw_vec_reg;

endmodule

>>> rtl/core/glyph_cell_width.sv
// Top level of glyph_cell_width: three-stage pipeline with an output register.
// Depends on gcw_pkg and gcw_range_hit.
//
// Usage: present a code point and its source byte count on in_data with
// in_valid; a beat moves when in_valid and in_ready are both high. One result
// beat per input beat leaves on out_data/out_valid/out_ready, in order.
// A beat passes the stage 1, stage 2 and stage 3 registers before out_valid.
// Throughput: one beat per cycle while out_ready does not stall the output;
// the range compares are registered in stage 1 and OR-reduced in stage 2.
// Stage 1: classify and compare against all ranges. Stage 2: reduce the
// range hits and build the result. Stage 3: output register.
// When the receiver stalls, the pipeline holds as a whole; in_ready follows
// out_ready or a free output slot, so no beat is lost or repeated.
// Reset clears all valid bits; out_valid is low after reset.
module glyph_cell_width
    import gcw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  gcw_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output gcw_out_t out_data
);

    logic     v1_reg, v2_reg, v3_reg;
    gcw_cls_t cls1_reg;
    logic [7:0] cp1_reg;
    gcw_out_t res2_reg, res3_reg;
    gcw_cls_t cls_next;
    gcw_out_t res_next;
    logic     adv;
    logic     zw_hit, dw_hit;

    // advance everything when the output slot is free or being taken
    assign adv      = !v3_reg || out_ready;
    assign in_ready = adv;

    // classify the incoming code point
    always_comb
    begin
        if (in_data.code_point < 21'h20 || in_data.code_point == 21'h7F)
            cls_next = CLS_CARET;
        else if (in_data.code_point >= 21'h80 &&
                 (in_data.code_point <= 21'h9F || in_data.source_bytes == 3'd1))
            cls_next = CLS_HEX;
        else if (in_data.code_point < SHORT_CUT_LIMIT)
            cls_next = CLS_ONE;
        else
            cls_next = CLS_TABLE;
    end

    gcw_range_hit u_range (
        .clk        (clk),
        .adv        (adv),
        .code_point (in_data.code_point),
        .zw_hit     (zw_hit),
        .dw_hit     (dw_hit)
    );

    // build the result beat
    always_comb
    begin
        res_next = '0;
        unique case (cls1_reg)
            CLS_CARET:
            begin
                res_next.cell_width      = 3'd2;
                res_next.is_escaped      = 1'b1;
                res_next.spelling_length = 3'd2;
                res_next.spell_char0     = CH_CARET;
                res_next.spell_char1     = (cp1_reg[6:0] == 7'h7F) ? CH_QUEST
                                           : (CH_AT + {2'd0, cp1_reg[4:0]});
            end
            CLS_HEX:
            begin
                res_next.cell_width      = 3'd4;
                res_next.is_escaped      = 1'b1;
                res_next.spelling_length = 3'd4;
                res_next.spell_char0     = CH_BSLASH;
                res_next.spell_char1     = CH_X;
                res_next.spell_char2     = hex_char(cp1_reg[7:4]);
                res_next.spell_char3     = hex_char(cp1_reg[3:0]);
            end
            CLS_ONE:   res_next.cell_width = 3'd1;
            CLS_TABLE: res_next.cell_width = zw_hit ? 3'd0 : (dw_hit ? 3'd2 : 3'd1);
            default:   res_next = '0;
        endcase
    end

    // advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // advance the payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cls1_reg <= cls_next;
            cp1_reg  <= in_data.code_point[7:0];
            res2_reg <= res_next;
            res3_reg <= res2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = res3_reg;

    // a stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed under stall");

    // escaped beats carry a non-zero spelling length
    a_esc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.is_escaped == (out_data.spelling_length != 3'd0)))
        else $error("escape flag and spelling length disagree");

    // an accepted beat occupies the first stage on the next cycle
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v1_reg)
        else $error("accepted beat lost in first stage");

endmodule
